### rtl/first_fit_block_allocator_assert.svh
// assertion macros used by the checker file
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// condition that must hold on every clock edge out of reset
`define FFA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int MEM_CELLS = 128;
  localparam int CELL_AW   = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
  localparam int CNT_W     = $clog2(MEM_CELLS + 1);
  localparam int CFG_W     = 8;
  localparam int LEN_W     = 8;
  localparam int HANDLE_W  = 16;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  // common width for comparing counts against the 8-bit fields
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CELLS_RESET = 8'd128;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEFRAG = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 2'd2;

  // per-cell verdict of the compare unit
  typedef struct packed {
    logic             free;
    logic             hit;
    logic             fit;
    logic [CMP_W-1:0] run_next;
  } ffa_cell_res_t;

endpackage

### rtl/ffa_cell_ram.sv
`timescale 1ns / 1ps

module ffa_cell_ram
  import ffa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [CELL_AW-1:0]  rd_addr_i,
  output logic [HANDLE_W-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [CELL_AW-1:0]  wr_addr_i,
  input  logic [HANDLE_W-1:0] wr_data_i
);

  logic [HANDLE_W-1:0]  mem [MEM_CELLS];
  logic [MEM_CELLS-1:0] written_q;
  logic [HANDLE_W-1:0]  rd_data_q;
  logic                 rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // a cell never written since reset reads as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

### rtl/ffa_cell_unit.sv
`timescale 1ns / 1ps

module ffa_cell_unit
  import ffa_pkg::*;
(
  input  logic [HANDLE_W-1:0] cell_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [CMP_W-1:0]    run_i,
  input  logic [LEN_W-1:0]    len_i,
  output ffa_cell_res_t       res_o
);

  logic             free;
  logic [CMP_W-1:0] run_next;

  assign free     = (cell_i == '0);
  assign run_next = free ? (run_i + CMP_W'(1)) : '0;

  assign res_o.free     = free;
  assign res_o.hit      = (handle_i != '0) && (cell_i == handle_i);
  assign res_o.fit      = free && (run_next == CMP_W'(len_i));
  assign res_o.run_next = run_next;

endmodule

### rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// channel   dir  tdata                        tuser
// s_axis    in   [7:0] length, [23:8] handle  [1:0] mode
// m_axis    out  [15:0] handle_res            [1:0] status
// cfg       in   cfg_wdata_i = cells_in_use, written when cfg_we_i is high
//
// one word at a time; each pass reads one cell per cycle from the single
// read port of the cell store, m = managed cells (min of cells_in_use, 128)
// alloc: a scan up to the first fit, a fill of the requested cells, then the output;
// zero length or a used-up counter goes straight to the output
// erase: a scan of the managed cells, then the output when illegal; defragment: a
// scan of the managed cells, then clearing each free managed cell and a step to finish
// cells read as free after reset; s_axis_tready is low while a pass runs, and a
// word held back on m_axis keeps the next pass with a result (and s_axis) waiting

module first_fit_block_allocator
  import ffa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // [7:0] length, [23:8] handle
  input  logic [MODE_W-1:0]    s_axis_tuser,  // [1:0] mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,  // [15:0] handle_res
  output logic [STATUS_W-1:0]  m_axis_tuser,  // [1:0] status
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_CLEAR,
    S_RESP
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    cells_q;
  logic [MODE_W-1:0]   mode_q;
  logic [LEN_W-1:0]    len_q;
  logic [HANDLE_W-1:0] hdl_q;
  logic [HANDLE_W-1:0] next_hdl_q;
  logic [CNT_W-1:0]    m_q;
  logic [CNT_W-1:0]    idx_q;
  logic [CNT_W-1:0]    dst_q;
  logic                p_vld_q;
  logic [CELL_AW-1:0]  p_idx_q;
  logic [CMP_W-1:0]    run_q;
  logic [CMP_W-1:0]    cnt_q;
  logic [CELL_AW-1:0]  wr_ptr_q;
  logic                found_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [HANDLE_W-1:0] res_handle_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [HANDLE_W-1:0] out_handle_q;

  logic                in_fire;
  logic [CNT_W-1:0]    managed;
  logic                rd_en;
  logic [HANDLE_W-1:0] rd_data;
  logic                wr_en;
  logic [CELL_AW-1:0]  wr_addr;
  logic [HANDLE_W-1:0] wr_data;
  logic                scan_done;
  logic                alloc_fit;
  ffa_cell_res_t       cres;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_handle_q;
  assign m_axis_tuser  = out_status_q;

  assign managed = (CMP_W'(cells_q) > CMP_W'(MEM_CELLS)) ? CNT_W'(MEM_CELLS)
                                                          : CNT_W'(cells_q);

  ffa_cell_unit u_unit (
    .cell_i   (rd_data),
    .handle_i (hdl_q),
    .run_i    (run_q),
    .len_i    (len_q),
    .res_o    (cres)
  );

  assign alloc_fit = (state_q == S_SCAN) && p_vld_q && (mode_q == MODE_ALLOC) && cres.fit;
  assign scan_done = (idx_q == m_q) && !p_vld_q;
  assign rd_en     = (state_q == S_SCAN) && (idx_q < m_q) && !alloc_fit;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx_q;
    wr_data = '0;
    case (state_q)
      S_SCAN: begin
        if (p_vld_q && (mode_q == MODE_ERASE) && cres.hit) begin
          wr_en = 1'b1;
        end else if (p_vld_q && (mode_q == MODE_DEFRAG) && !cres.free) begin
          wr_en   = 1'b1;
          wr_addr = dst_q[CELL_AW-1:0];
          wr_data = rd_data;
        end
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = wr_ptr_q;
        wr_data = next_hdl_q;
      end
      S_CLEAR: begin
        wr_en   = (dst_q < m_q);
        wr_addr = dst_q[CELL_AW-1:0];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  ffa_cell_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[CELL_AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cells_q      <= CELLS_RESET;
      mode_q       <= MODE_ALLOC;
      len_q        <= '0;
      hdl_q        <= '0;
      next_hdl_q   <= HANDLE_W'(1);
      m_q          <= '0;
      idx_q        <= '0;
      dst_q        <= '0;
      p_vld_q      <= 1'b0;
      p_idx_q      <= '0;
      run_q        <= '0;
      cnt_q        <= '0;
      wr_ptr_q     <= '0;
      found_q      <= 1'b0;
      res_status_q <= STATUS_OK;
      res_handle_q <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_handle_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cells_q <= cfg_wdata_i;
      end
      // in S_RESP an accepted word is replaced right away
      if (m_axis_tready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      p_vld_q <= rd_en;
      if (rd_en) begin
        p_idx_q <= idx_q[CELL_AW-1:0];
        idx_q   <= idx_q + CNT_W'(1);
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            mode_q  <= s_axis_tuser;
            len_q   <= s_axis_tdata[7:0];
            hdl_q   <= s_axis_tdata[23:8];
            m_q     <= managed;
            idx_q   <= '0;
            dst_q   <= '0;
            run_q   <= '0;
            found_q <= 1'b0;
            case (s_axis_tuser)
              MODE_ALLOC: begin
                if (next_hdl_q == '0) begin
                  res_status_q <= STATUS_NULL;
                  res_handle_q <= '0;
                  state_q      <= S_RESP;
                end else if (s_axis_tdata[7:0] == '0) begin
                  // zero length takes a handle and marks nothing
                  res_status_q <= STATUS_OK;
                  res_handle_q <= next_hdl_q;
                  next_hdl_q   <= next_hdl_q + HANDLE_W'(1);
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              MODE_ERASE, MODE_DEFRAG: begin
                state_q <= S_SCAN;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (p_vld_q) begin
            case (mode_q)
              MODE_ALLOC: begin
                run_q <= cres.run_next;
              end
              MODE_ERASE: begin
                if (cres.hit) begin
                  found_q <= 1'b1;
                end
              end
              MODE_DEFRAG: begin
                if (!cres.free) begin
                  dst_q <= dst_q + CNT_W'(1);
                end
              end
              default: begin
                run_q <= run_q;
              end
            endcase
          end
          if (alloc_fit) begin
            // fill the run downward from its last cell
            wr_ptr_q <= p_idx_q;
            cnt_q    <= CMP_W'(len_q);
            state_q  <= S_FILL;
          end else if (scan_done) begin
            case (mode_q)
              MODE_ALLOC: begin
                res_status_q <= STATUS_NULL;
                res_handle_q <= '0;
                state_q      <= S_RESP;
              end
              MODE_ERASE: begin
                res_status_q <= STATUS_ILLEGAL;
                res_handle_q <= '0;
                state_q      <= found_q ? S_IDLE : S_RESP;
              end
              default: begin
                state_q <= S_CLEAR;
              end
            endcase
          end
        end

        S_FILL: begin
          wr_ptr_q <= wr_ptr_q - CELL_AW'(1);
          cnt_q    <= cnt_q - CMP_W'(1);
          if (cnt_q == CMP_W'(1)) begin
            res_status_q <= STATUS_OK;
            res_handle_q <= next_hdl_q;
            next_hdl_q   <= next_hdl_q + HANDLE_W'(1);
            state_q      <= S_RESP;
          end
        end

        S_CLEAR: begin
          if (dst_q < m_q) begin
            dst_q <= dst_q + CNT_W'(1);
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_RESP: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_handle_q <= res_handle_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ffa_checker.sv
`timescale 1ns / 1ps
`include "first_fit_block_allocator_assert.svh"

module ffa_checker
  import ffa_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [MODE_W-1:0]   s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [15:0]         m_axis_tdata,
  input logic [STATUS_W-1:0] m_axis_tuser
);

  logic op_taken;

  assign op_taken = s_axis_tvalid && s_axis_tready &&
                    ((s_axis_tuser == MODE_ALLOC) || (s_axis_tuser == MODE_ERASE) ||
                     (s_axis_tuser == MODE_DEFRAG));

  // a stalled result word holds
  `FFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

  // failures carry no handle
  `FFA_ASSERT_ALWAYS(a_fail_zero, !m_axis_tvalid || (m_axis_tuser == STATUS_OK) || (m_axis_tdata == '0), "failed result carries a handle")

  // a granted block never gets the null handle
  `FFA_ASSERT_ALWAYS(a_ok_nonzero, !m_axis_tvalid || (m_axis_tuser != STATUS_OK) || (m_axis_tdata != '0), "allocated handle is zero")

  // a real operation closes the input once it is taken
  `FFA_ASSERT_NEXT(a_busy_after_op, op_taken, !s_axis_tready, "input ready right after an operation")

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (.*);

### bench/first_fit_block_allocator_tb.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;
  import ffa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  // longest pass: full scan, full fill and the output stage
  localparam int IDLE_PAUSE = 320;
  localparam int HOLD_CYCLES = 700;
  localparam int PHASE_WORDS = 100;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_res;
  } alloc_result_t;

  class cell_owner_tracker;
    logic [HANDLE_W-1:0] owner [MEM_CELLS];
    logic [HANDLE_W-1:0] next_handle;
    logic [CFG_W-1:0]    cells_cfg;
    alloc_result_t       pending_results[$];
    int unsigned         mismatch_count;

    function new();
      foreach (owner[k]) owner[k] = '0;
      next_handle = 16'd1;
      cells_cfg = CELLS_RESET;
      mismatch_count = 0;
    endfunction

    function int managed();
      return (int'(cells_cfg) > MEM_CELLS) ? MEM_CELLS : int'(cells_cfg);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    function void note_word(logic [MODE_W-1:0] mode, logic [LEN_W-1:0] len,
                            logic [HANDLE_W-1:0] hnd);
      int m;
      int run;
      int start;
      int dst;
      bit found;
      alloc_result_t r;
      m = managed();
      run = 0;
      start = 0;
      dst = 0;
      found = 1'b0;
      case (mode)
        MODE_ALLOC: begin
          r.status = STATUS_NULL;
          r.handle_res = '0;
          if (next_handle != '0) begin
            if (len == '0) found = 1'b1;
            for (int k = 0; k < m && !found; k++) begin
              if (owner[k] == '0) begin
                run++;
                if (run == int'(len)) begin
                  start = k + 1 - int'(len);
                  found = 1'b1;
                end
              end else begin
                run = 0;
              end
            end
            if (found) begin
              for (int k = 0; k < int'(len); k++) owner[start + k] = next_handle;
              r.status = STATUS_OK;
              r.handle_res = next_handle;
              next_handle = next_handle + 16'd1;
            end
          end
          pending_results.push_back(r);
        end
        MODE_ERASE: begin
          if (hnd != '0) begin
            for (int k = 0; k < m; k++) begin
              if (owner[k] == hnd) begin
                owner[k] = '0;
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            r.status = STATUS_ILLEGAL;
            r.handle_res = '0;
            pending_results.push_back(r);
          end
        end
        MODE_DEFRAG: begin
          for (int k = 0; k < m; k++) begin
            if (owner[k] != '0) begin
              owner[dst] = owner[k];
              dst++;
            end
          end
          for (int k = dst; k < m; k++) owner[k] = '0;
        end
        default: ;
      endcase
    endfunction

    task check_word(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] hres);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word, status %0d handle %0d", status, hres));
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (hres !== want.handle_res)
        report($sformatf("handle %0d, want %0d", hres, want.handle_res));
    endtask

    task finish_check();
      while (pending_results.size() != 0) begin
        report($sformatf("result never came, status %0d handle %0d",
                         pending_results[0].status, pending_results[0].handle_res));
        void'(pending_results.pop_front());
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;   // [7:0] length, [23:8] handle
  logic [MODE_W-1:0]   s_axis_tuser;   // [1:0] mode
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [15:0] handle_res
  logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_wdata_i;

  cell_owner_tracker sb = new();
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;
  bit hold_req = 1'b0;
  int unsigned cycle_count = 0;
  int cells_seq [11] = '{128, 1, 0, 255, 16, 200, 37, 128, 64, 3, 128};

  first_fit_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("first_fit_block_allocator_tb: errors");
    $finish;
  end

  // result side: sample at the rising edge, change ready at the falling edge
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tuser, m_axis_tdata);
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_out && $urandom_range(99) < 25) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                           input logic [HANDLE_W-1:0] hnd);
    int gap;
    gap = 0;
    if (idle_in && $urandom_range(99) < 25)
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hnd, len};
    s_axis_tuser <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(mode, len, hnd);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // only while idle: drain, let a silent erase or defragment finish, then write
  task automatic set_cells(input logic [CFG_W-1:0] val);
    wait_drained();
    repeat (IDLE_PAUSE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    sb.cells_cfg = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_word();
    int pick;
    int m;
    logic [LEN_W-1:0] len;
    logic [HANDLE_W-1:0] hnd;
    pick = $urandom_range(99);
    m = sb.managed();
    len = LEN_W'($urandom);
    hnd = HANDLE_W'($urandom);
    if (pick < 50) begin
      case ($urandom_range(9))
        0: len = '0;
        1: len = LEN_W'($urandom);
        2: len = LEN_W'(m);
        default: len = LEN_W'($urandom_range(1, m / 4 + 1));
      endcase
      send_word(MODE_ALLOC, len, hnd);
    end else if (pick < 75) begin
      send_word(MODE_ERASE, len, sb.next_handle - HANDLE_W'($urandom_range(1, 24)));
    end else if (pick < 84) begin
      send_word(MODE_ERASE, len, $urandom_range(1) ? hnd : '0);
    end else if (pick < 97) begin
      send_word(MODE_DEFRAG, len, hnd);
    end else begin
      send_word(MODE_UNUSED, len, hnd);
    end
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_ALLOC;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part on the full store
    send_word(MODE_ALLOC, 8'd0, 16'hFFFF);      // zero length takes a handle
    send_word(MODE_ALLOC, 8'd1, 16'h0000);
    send_word(MODE_ALLOC, 8'd128, 16'h0000);    // one cell short
    send_word(MODE_ALLOC, 8'd127, 16'h0000);
    send_word(MODE_ALLOC, 8'd1, 16'h0000);      // store full
    send_word(MODE_ERASE, 8'd0, 16'h0000);      // zero handle
    send_word(MODE_ERASE, 8'hFF, 16'hFFFF);     // never given out
    send_word(MODE_ERASE, 8'd0, 16'd1);         // owns no cell
    send_word(MODE_ERASE, 8'd0, 16'd2);
    send_word(MODE_ALLOC, 8'd2, 16'h0000);
    send_word(MODE_ALLOC, 8'd1, 16'h0000);
    send_word(MODE_UNUSED, 8'hA5, 16'h5A5A);
    send_word(MODE_ERASE, 8'd0, 16'd3);
    send_word(MODE_ALLOC, 8'd5, 16'h0000);
    send_word(MODE_ALLOC, 8'd3, 16'h0000);
    send_word(MODE_ERASE, 8'd0, 16'd5);
    send_word(MODE_DEFRAG, 8'd0, 16'h0000);
    send_word(MODE_ALLOC, 8'd124, 16'h0000);
    send_word(MODE_ALLOC, 8'd255, 16'h0000);
    send_word(MODE_ALLOC, 8'd200, 16'h0000);
    send_word(MODE_ERASE, 8'd0, 16'd4);
    send_word(MODE_ERASE, 8'd0, 16'd6);
    send_word(MODE_ERASE, 8'd0, 16'd7);
    send_word(MODE_ALLOC, 8'd128, 16'h0000);
    send_word(MODE_DEFRAG, 8'd0, 16'h0000);
    send_word(MODE_ERASE, 8'd0, 16'd8);
    send_word(MODE_DEFRAG, 8'd0, 16'h0000);
    send_word(MODE_ERASE, 8'h55, 16'hAAAA);

    foreach (cells_seq[p]) begin
      if (p == 3) begin
        idle_in = 1'b0;
        idle_out = 1'b0;
      end else begin
        idle_in = 1'b1;
        idle_out = 1'b1;
      end
      set_cells(CFG_W'(p == 10 ? $urandom_range(1, 255) : cells_seq[p]));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // back pressure fills the output and then stalls the input
        if (p == 0 && i == 30) hold_req = 1'b1;
        if (p == 1 && i == 50) wait_drained();
        random_word();
      end
    end

    idle_in = 1'b0;
    idle_out = 1'b0;
    set_cells(8'd1);
    send_word(MODE_ALLOC, 8'd0, 16'h0000);
    send_word(MODE_ALLOC, 8'd1, 16'h0000);
    send_word(MODE_ERASE, 8'd0, 16'hFFFF);
    send_word(MODE_ALLOC, 8'd1, 16'h0000);
    send_word(MODE_ERASE, 8'd0, 16'h0000);
    send_word(MODE_DEFRAG, 8'd0, 16'h0000);
    idle_in = 1'b1;
    idle_out = 1'b1;
    set_cells(8'd128);
    send_word(MODE_ALLOC, 8'd5, 16'h0000);
    send_word(MODE_UNUSED, 8'd0, 16'h0000);
    send_word(MODE_ERASE, 8'd0, 16'd1);

    wait_drained();
    repeat (IDLE_PAUSE) @(posedge clk_i);
    sb.finish_check();
    if (sb.mismatch_count == 0) begin
      $display("first_fit_block_allocator_tb: clean");
    end else begin
      $display("first_fit_block_allocator_tb: errors");
    end
    $finish;
  end

endmodule
